FILE: hdl/plle_pkg.sv
// shared command and status codes of the positional linked list engine
`default_nettype none
package plle_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOB      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ELEM     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

endpackage
`default_nettype wire

FILE: hdl/positional_linked_list_engine.sv
// positional linked list engine: ordered list of signed words in a node store
// insert scans the occupancy map slot by slot for the lowest free one; at the head it then
// writes the node, else it walks to the predecessor, writes the node and relinks it
// delete compares and hops node by node; a status decided at acceptance goes out via S_RESP
// read-out: one word a cycle unless the output stalls
// one command in flight, next taken at the edge after its last word is loaded; reset empties
// the list (head null, occupancy map and count zero), node and link memories are not cleared
`default_nettype none
module positional_linked_list_engine #(
    parameter int NODES = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // command channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic        [plle_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic signed [plle_pkg::VALUE_W-1:0]   i_value,
    input  wire logic        [plle_pkg::POS_W-1:0]     i_position,
    // result channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic             [plle_pkg::STATUS_W-1:0]  o_status,
    output logic signed      [plle_pkg::VALUE_W-1:0]   o_element,
    output logic                                       o_last
);

    // index width holds the null marker NODES, slot width addresses the store
    localparam int IW = $clog2(NODES + 1);
    localparam int SW = $clog2(NODES);
    localparam int VW = plle_pkg::VALUE_W;
    localparam int PW = plle_pkg::POS_W;

    localparam logic [IW-1:0] NULL_IDX = IW'(NODES);
    localparam logic [IW-1:0] LAST_STEP = IW'(NODES - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;  // scan occupancy map for lowest free slot
    localparam logic [2:0] S_WALK  = 3'd2;  // insert: hop to node position-1
    localparam logic [2:0] S_FIX   = 3'd3;  // insert: relink predecessor to new node
    localparam logic [2:0] S_DEL   = 3'd4;  // delete: compare and hop
    localparam logic [2:0] S_RDO   = 3'd5;  // read-out: emit one word per node
    localparam logic [2:0] S_RESP  = 3'd6;  // single status word

    logic [2:0] r_state, n_state;

    // list bookkeeping
    logic [IW-1:0]    r_head, n_head;
    logic [NODES-1:0] r_occ, n_occ;
    logic [IW-1:0]    r_count, n_count;

    // per-command working registers
    logic signed [VW-1:0] r_value, n_value;
    logic [PW-1:0]        r_pos, n_pos;
    logic [PW-1:0]        r_hops, n_hops;
    logic [SW-1:0]        r_scan, n_scan;
    logic [SW-1:0]        r_slot, n_slot;
    logic [IW-1:0]        r_cur, n_cur;
    logic [IW-1:0]        r_prev, n_prev;
    logic [IW-1:0]        r_steps, n_steps;
    logic [plle_pkg::STATUS_W-1:0] r_status, n_status;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic [plle_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic signed [VW-1:0]          r_out_elem, n_out_elem;
    logic                          r_out_last, n_out_last;

    // memory ports
    logic [SW-1:0]        ram_raddr;
    logic                 val_we;
    logic [SW-1:0]        val_waddr;
    logic signed [VW-1:0] val_wdata;
    logic [VW-1:0]        val_rdata;
    logic                 lnk_we;
    logic [SW-1:0]        lnk_waddr;
    logic [IW-1:0]        lnk_wdata;
    logic [IW-1:0]        lnk_rdata;

    logic in_accept;
    logic out_free;

    function automatic logic idx_valid(input logic [IW-1:0] idx);
        return idx < NULL_IDX;
    endfunction

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // node values
    plle_ram #(
        .WIDTH(VW),
        .DEPTH(NODES)
    ) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(val_waddr),
        .i_wdata(val_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(val_rdata)
    );

    // next links, null marker stored as NODES
    plle_ram #(
        .WIDTH(IW),
        .DEPTH(NODES)
    ) u_lnk_ram (
        .i_clk  (i_clk),
        .i_we   (lnk_we),
        .i_waddr(lnk_waddr),
        .i_wdata(lnk_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(lnk_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_occ        = r_occ;
        n_count      = r_count;
        n_value      = r_value;
        n_pos        = r_pos;
        n_hops       = r_hops;
        n_scan       = r_scan;
        n_slot       = r_slot;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_steps      = r_steps;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_elem   = r_out_elem;
        n_out_last   = r_out_last;

        // re-read the current node by default so the read data stays put
        ram_raddr = r_cur[SW-1:0];
        val_we    = 1'b0;
        val_waddr = r_slot;
        val_wdata = r_value;
        lnk_we    = 1'b0;
        lnk_waddr = r_slot;
        lnk_wdata = r_head;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_value = i_value;
                    n_pos   = i_position;
                    n_cur   = r_head;
                    n_prev  = NULL_IDX;
                    n_steps = '0;
                    n_scan  = '0;
                    ram_raddr = r_head[SW-1:0];
                    case (i_cmd)
                        plle_pkg::CMD_INSERT: begin
                            // full is checked ahead of the position
                            if (r_count >= NULL_IDX) begin
                                n_status = plle_pkg::ST_FULL;
                                n_state  = S_RESP;
                            end else if (i_position == '0 ||
                                         9'(i_position) > 9'(r_count) + 9'd1) begin
                                n_status = plle_pkg::ST_OOB;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        plle_pkg::CMD_DELETE: begin
                            if (idx_valid(r_head)) begin
                                n_state = S_DEL;
                            end else begin
                                n_status = plle_pkg::ST_NOTFOUND;
                                n_state  = S_RESP;
                            end
                        end
                        plle_pkg::CMD_READ: begin
                            if (idx_valid(r_head)) begin
                                n_state = S_RDO;
                            end else begin
                                n_status = plle_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end
                        end
                        default: begin
                            // unassigned command: dropped without a result
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_ALLOC: begin
                // count below NODES guarantees a free slot before the scan runs out
                if (!r_occ[r_scan]) begin
                    n_slot = r_scan;
                    if (r_pos == PW'(1)) begin
                        // new head: write node and swing the head pointer
                        val_we    = 1'b1;
                        val_waddr = r_scan;
                        lnk_we    = 1'b1;
                        lnk_waddr = r_scan;
                        lnk_wdata = r_head;
                        n_head    = IW'(r_scan);
                        n_occ[r_scan] = 1'b1;
                        n_count   = r_count + IW'(1);
                        n_status  = plle_pkg::ST_OK;
                        n_state   = S_RESP;
                    end else begin
                        n_hops    = r_pos - PW'(2);
                        n_cur     = r_head;
                        ram_raddr = r_head[SW-1:0];
                        n_state   = S_WALK;
                    end
                end else begin
                    n_scan = r_scan + SW'(1);
                end
            end

            S_WALK: begin
                // link data belongs to r_cur
                if (r_hops == '0) begin
                    // r_cur is the predecessor: new node takes over its next link
                    val_we    = 1'b1;
                    val_waddr = r_slot;
                    lnk_we    = 1'b1;
                    lnk_waddr = r_slot;
                    lnk_wdata = lnk_rdata;
                    n_state   = S_FIX;
                end else if (!idx_valid(lnk_rdata)) begin
                    n_status = plle_pkg::ST_OOB;
                    n_state  = S_RESP;
                end else begin
                    n_cur     = lnk_rdata;
                    ram_raddr = lnk_rdata[SW-1:0];
                    n_hops    = r_hops - PW'(1);
                end
            end

            S_FIX: begin
                lnk_we    = 1'b1;
                lnk_waddr = r_cur[SW-1:0];
                lnk_wdata = IW'(r_slot);
                n_occ[r_slot] = 1'b1;
                n_count   = r_count + IW'(1);
                n_status  = plle_pkg::ST_OK;
                n_state   = S_RESP;
            end

            S_DEL: begin
                if ($signed(val_rdata) == r_value) begin
                    // unlink the match, from its predecessor or from the head
                    if (idx_valid(r_prev)) begin
                        lnk_we    = 1'b1;
                        lnk_waddr = r_prev[SW-1:0];
                        lnk_wdata = lnk_rdata;
                    end else begin
                        n_head = lnk_rdata;
                    end
                    n_occ[r_cur[SW-1:0]] = 1'b0;
                    if (r_count != '0) begin
                        n_count = r_count - IW'(1);
                    end
                    n_status = plle_pkg::ST_OK;
                    n_state  = S_RESP;
                end else if (!idx_valid(lnk_rdata) || r_steps == LAST_STEP) begin
                    n_status = plle_pkg::ST_NOTFOUND;
                    n_state  = S_RESP;
                end else begin
                    n_prev    = r_cur;
                    n_cur     = lnk_rdata;
                    ram_raddr = lnk_rdata[SW-1:0];
                    n_steps   = r_steps + IW'(1);
                end
            end

            S_RDO: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = plle_pkg::ST_ELEM;
                    n_out_elem   = $signed(val_rdata);
                    if (!idx_valid(lnk_rdata) || r_steps == LAST_STEP) begin
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_out_last = 1'b0;
                        n_cur      = lnk_rdata;
                        ram_raddr  = lnk_rdata[SW-1:0];
                        n_steps    = r_steps + IW'(1);
                    end
                end
            end

            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_elem   = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NULL_IDX;
            r_occ       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_occ       <= n_occ;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_value      <= n_value;
        r_pos        <= n_pos;
        r_hops       <= n_hops;
        r_scan       <= n_scan;
        r_slot       <= n_slot;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_steps      <= n_steps;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_elem   <= n_out_elem;
        r_out_last   <= n_out_last;
    end

    // a new command is taken once the previous one has loaded its last word into the output register
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_element   = r_out_elem;
    assign o_last      = r_out_last;

endmodule
`default_nettype wire

FILE: hdl/plle_ram.sv
// generic single write port ram with one registered read port
`default_nettype none
module plle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
